[hw/rtl/rgrb_pkg.sv]
// ---------------------------------------------------------------------------
// rgrb_pkg
// shared types and constants for the glyph row blender
// ---------------------------------------------------------------------------
package rgrb_pkg;

  localparam int unsigned COL_W   = 11;
  localparam int unsigned OUT_COL_W = 10;
  localparam int unsigned COL_SAT = 2047;

  localparam logic [3:0]  CODE_SKIP   = 4'd14;
  localparam logic [3:0]  CODE_WHITE  = 4'd15;
  localparam logic [15:0] WHITE_PIXEL = 16'hFFFF;
  localparam logic [4:0]  RB_MAX      = 5'd31;
  localparam logic [5:0]  G_MAX       = 6'd63;

  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_SKIP  = 2'd1,
    PEND_WHITE = 2'd2
  } pend_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic load;
    logic decode;
    logic white_step;
  } cmd_t;

  typedef struct packed {
    pend_t      pend;
    logic [3:0] nib;
    logic       cnt_last;
    logic       writable;
    logic       slot_free;
  } sts_t;

endpackage

[hw/rtl/rgrb_if.sv]
// ---------------------------------------------------------------------------
// rgrb channel interfaces
// valid/ready channels for nibbles, pixel writes and the origin register
// ---------------------------------------------------------------------------
interface rgrb_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  nibble;
  logic [15:0] background;
  logic        new_line;
  modport source (output valid, nibble, background, new_line, input ready);
  modport sink   (input valid, nibble, background, new_line, output ready);
endinterface

interface rgrb_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  column;
  logic [15:0] pixel;
  logic        last;
  modport source (output valid, column, pixel, last, input ready);
  modport sink   (input valid, column, pixel, last, output ready);
endinterface

interface rgrb_cfg_if;
  logic       valid;
  logic       ready;
  logic [9:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[hw/rtl/rgrb_ctrl.sv]
// ---------------------------------------------------------------------------
// rgrb_ctrl
// sequencer: accepts a nibble, decodes it, then walks any white run
// ---------------------------------------------------------------------------
module rgrb_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rgrb_pkg::sts_t  sts,
  output rgrb_pkg::cmd_t  cmd
);

  rgrb_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rgrb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rgrb_pkg::ST_IDLE: begin
        if (in_valid) state_next = rgrb_pkg::ST_DECODE;
      end
      rgrb_pkg::ST_DECODE: begin
        if (sts.slot_free) begin
          if (sts.pend == rgrb_pkg::PEND_WHITE && sts.nib != 4'd0) begin
            state_next = rgrb_pkg::ST_RUN;
          end else begin
            state_next = rgrb_pkg::ST_IDLE;
          end
        end
      end
      rgrb_pkg::ST_RUN: begin
        if (sts.slot_free && (!sts.writable || sts.cnt_last)) begin
          state_next = rgrb_pkg::ST_IDLE;
        end
      end
      default: state_next = rgrb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd.load       = 1'b0;
    cmd.decode     = 1'b0;
    cmd.white_step = 1'b0;
    case (state)
      rgrb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      rgrb_pkg::ST_DECODE: cmd.decode     = sts.slot_free;
      rgrb_pkg::ST_RUN:    cmd.white_step = sts.slot_free;
      default: ;
    endcase
  end

endmodule

[hw/rtl/rgrb_dp.sv]
// ---------------------------------------------------------------------------
// rgrb_dp
// column, pending run and count registers, blend arithmetic, output register
// ---------------------------------------------------------------------------
module rgrb_dp #(
  parameter int MAX_COLUMNS = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rgrb_pkg::cmd_t        cmd,
  output rgrb_pkg::sts_t        sts,
  input  logic [3:0]            in_nibble,
  input  logic [15:0]           in_background,
  input  logic                  in_new_line,
  input  logic                  cfg_valid,
  input  logic [9:0]            cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [9:0]            out_column,
  output logic [15:0]           out_pixel,
  output logic                  out_last
);

  localparam int LIMIT = (MAX_COLUMNS < int'(rgrb_pkg::COL_SAT)) ?
                         MAX_COLUMNS : int'(rgrb_pkg::COL_SAT);

  logic [9:0]  x_origin;
  logic [10:0] run_column, run_column_next;
  rgrb_pkg::pend_t pend, pend_next;
  logic [3:0]  cnt, cnt_next;
  logic [3:0]  nib;
  logic [15:0] bg;

  logic        emit;
  logic [15:0] emit_pixel;
  logic        emit_last;

  logic        writable, writable_nxt;
  logic [11:0] col_plus_one;
  logic [11:0] adv_sum;
  logic [3:0]  adv_amt;
  logic [10:0] adv_col;

  logic [7:0]  kc;
  logic [4:0]  r_in, b_in, r_new, b_new;
  logic [5:0]  g_in, g_new;
  logic [12:0] r_prod, b_prod;
  logic [13:0] g_prod;
  logic [15:0] blended;

  assign writable     = {1'b0, run_column} < 12'(LIMIT);
  assign col_plus_one = {1'b0, run_column} + 12'd1;
  assign writable_nxt = col_plus_one < 12'(LIMIT);

  // saturating column advance
  assign adv_sum = {1'b0, run_column} + {8'd0, adv_amt};
  assign adv_col = (adv_sum > 12'(rgrb_pkg::COL_SAT)) ? 11'(rgrb_pkg::COL_SAT)
                                                      : adv_sum[10:0];

  // blend toward white, code*19 by shift and add
  assign kc     = {nib, 4'd0} + {3'd0, nib, 1'b0} + {4'd0, nib};
  assign r_in   = bg[4:0];
  assign g_in   = bg[10:5];
  assign b_in   = bg[15:11];
  assign r_prod = 13'(rgrb_pkg::RB_MAX - r_in) * 13'(kc);
  assign g_prod = 14'(rgrb_pkg::G_MAX - g_in) * 14'(kc);
  assign b_prod = 13'(rgrb_pkg::RB_MAX - b_in) * 13'(kc);
  assign r_new  = r_in + r_prod[12:8];
  assign g_new  = g_in + g_prod[13:8];
  assign b_new  = b_in + b_prod[12:8];
  assign blended = {b_new, g_new, r_new};

  always_comb begin
    run_column_next = run_column;
    pend_next       = pend;
    cnt_next        = cnt;
    emit            = 1'b0;
    emit_pixel      = rgrb_pkg::WHITE_PIXEL;
    emit_last       = 1'b1;
    adv_amt         = 4'd1;
    if (cmd.decode) begin
      pend_next = rgrb_pkg::PEND_NONE;
      case (pend)
        rgrb_pkg::PEND_SKIP: begin
          adv_amt         = nib;
          run_column_next = adv_col;
        end
        rgrb_pkg::PEND_WHITE: begin
          cnt_next = nib;
        end
        default: begin
          if (nib == rgrb_pkg::CODE_SKIP) begin
            pend_next = rgrb_pkg::PEND_SKIP;
          end else if (nib == rgrb_pkg::CODE_WHITE) begin
            pend_next = rgrb_pkg::PEND_WHITE;
          end else begin
            emit            = writable;
            emit_pixel      = blended;
            run_column_next = adv_col;
          end
        end
      endcase
    end else if (cmd.white_step) begin
      if (writable) begin
        emit            = 1'b1;
        emit_last       = (cnt == 4'd1) || !writable_nxt;
        run_column_next = adv_col;
        cnt_next        = cnt - 4'd1;
      end else begin
        adv_amt         = cnt;
        run_column_next = adv_col;
        cnt_next        = 4'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_origin   <= 10'd0;
      run_column <= 11'd0;
      pend       <= rgrb_pkg::PEND_NONE;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) x_origin <= cfg_data;
      if (cmd.load && in_new_line) begin
        run_column <= {1'b0, x_origin};
        pend       <= rgrb_pkg::PEND_NONE;
      end else begin
        run_column <= run_column_next;
        pend       <= pend_next;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt <= cnt_next;
    if (cmd.load) begin
      nib <= in_nibble;
      bg  <= in_background;
    end
    if (emit) begin
      out_column <= run_column[9:0];
      out_pixel  <= emit_pixel;
      out_last   <= emit_last;
    end
  end

  assign sts.pend      = pend;
  assign sts.nib       = nib;
  assign sts.cnt_last  = (cnt == 4'd1);
  assign sts.writable  = writable;
  assign sts.slot_free = !out_valid || out_ready;

endmodule

[hw/rtl/rle_glyph_row_blender.sv]
// ---------------------------------------------------------------------------
// rle_glyph_row_blender
// run-length glyph row decoder with rgb565 blend toward white
//
//   channel  dir  carries
//   src      in   nibble, background, new_line
//   dst      out  column, pixel, last
//   cfg      in   data (x_origin)
//
// a nibble is accepted, then decoded; a white run is then walked one pixel at a
// time, with one more step to skip a clipped remainder.
// rst is synchronous and clears the column, pending run and x_origin.
// a stalled dst holds the decoder; src is taken again once the item is done.
// ---------------------------------------------------------------------------
module rle_glyph_row_blender #(
  parameter int MAX_COLUMNS = 1024
) (
  input logic              clk,
  input logic              rst,
  rgrb_in_if.sink          src,
  rgrb_out_if.source       dst,
  rgrb_cfg_if.sink         cfg
);

  rgrb_pkg::cmd_t cmd;
  rgrb_pkg::sts_t sts;

  assign cfg.ready = 1'b1;

  rgrb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (src.valid),
    .in_ready (src.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rgrb_dp #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .in_nibble     (src.nibble),
    .in_background (src.background),
    .in_new_line   (src.new_line),
    .cfg_valid     (cfg.valid),
    .cfg_data      (cfg.data),
    .out_valid     (dst.valid),
    .out_ready     (dst.ready),
    .out_column    (dst.column),
    .out_pixel     (dst.pixel),
    .out_last      (dst.last)
  );

endmodule
